FILE: rtl/assert_macros.svh
// Assertion macros used by the sequencer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/clcd_pkg.sv
// Types, constants and helper functions of the character LCD 4-bit sequencer.
package clcd_pkg;

    // Request codes
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_CURSOR = 3'd2;
    localparam logic [2:0] CMD_CHAR   = 3'd3;
    localparam logic [2:0] CMD_NUMBER = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER  = 2'd2;

    localparam int SETTLE_W      = 10;
    localparam int LONG_W        = 14;
    localparam int POWER_W       = 16;
    localparam int WAIT_BEFORE_W = 16;
    localparam int WAIT_AFTER_W  = 14;

    localparam logic [SETTLE_W-1:0] SETTLE_RST = 10'd50;
    localparam logic [LONG_W-1:0]   LONG_RST   = 14'd2000;
    localparam logic [POWER_W-1:0]  POWER_RST  = 16'd40000;

    localparam logic [WAIT_AFTER_W-1:0]  WAIT_AFTER_MAX = 14'h3FFF;
    localparam logic [WAIT_BEFORE_W-1:0] INIT_WAIT_2    = 16'd5000;
    localparam logic [WAIT_BEFORE_W-1:0] INIT_WAIT_3    = 16'd150;

    localparam logic [3:0] INIT_NIB_3    = 4'h3;
    localparam logic [3:0] INIT_NIB_2    = 4'h2;
    localparam logic [1:0] INIT_LAST_IDX = 2'd3;

    localparam logic [7:0] BYTE_CLEAR   = 8'h01;
    localparam logic [7:0] BYTE_HOME    = 8'h02;
    localparam logic [7:0] SET_ADDR     = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    // Decimal conversion
    localparam int NUM_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
    localparam int BIT_CNT_W  = $clog2(NUM_W);

    localparam int LAST_COLUMN_DEF = 15;
    localparam int MAX_DIGITS_DEF  = 10;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  byte_value;
        logic        line;
        logic [7:0]  column;
        logic [31:0] number;
    } in_item_t;

    typedef struct packed {
        logic                     rs;
        logic [3:0]               nibble;
        logic [WAIT_BEFORE_W-1:0] wait_before_us;
        logic [WAIT_AFTER_W-1:0]  wait_after_us;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle;
        logic [LONG_W-1:0]   long_wait;
        logic [POWER_W-1:0]  power_on;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INIT_NIB,
        ST_CONVERT,
        ST_SKIP,
        ST_SEND_HI,
        ST_SEND_LO
    } state_t;

    typedef enum logic [1:0] {
        OSEL_INIT,
        OSEL_HI,
        OSEL_LO
    } out_sel_t;

    typedef struct packed {
        logic latch;
        logic conv_step;
        logic idx_top;
        logic idx_clr;
        logic idx_inc;
        logic idx_dec;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       conv_done;
        logic       idx_zero;
        logic       idx_init_last;
        logic       digit_zero;
        logic       upper_nz;
    } dp_stat_t;

    typedef struct packed {
        out_sel_t sel;
        logic     last;
    } out_ctl_t;

    // Command bytes of the init sequence after the four wake-up nibbles.
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h28;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h06;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/clcd_cfg.sv
// Configuration registers of the sequencer.
module clcd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output clcd_pkg::cfg_t                 cfg
);
    import clcd_pkg::*;

    logic [SETTLE_W-1:0] settle_reg;
    logic [LONG_W-1:0]   long_reg;
    logic [POWER_W-1:0]  power_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_RST;
            long_reg   <= LONG_RST;
            power_reg  <= POWER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SETTLE: settle_reg <= cfg_wdata[SETTLE_W-1:0];
                CFG_LONG:   long_reg   <= cfg_wdata[LONG_W-1:0];
                CFG_POWER:  power_reg  <= cfg_wdata[POWER_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg.settle    = settle_reg;
    assign cfg.long_wait = long_reg;
    assign cfg.power_on  = power_reg;

endmodule

FILE: rtl/clcd_dp.sv
// Datapath: request latch, binary to BCD converter, digit index and transfer payload.
module clcd_dp #(
    parameter int LAST_COLUMN = clcd_pkg::LAST_COLUMN_DEF,
    parameter int MAX_DIGITS  = clcd_pkg::MAX_DIGITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  clcd_pkg::in_item_t  s_data,
    input  clcd_pkg::cfg_t      cfg,
    input  clcd_pkg::dp_cmd_t   cmd,
    input  clcd_pkg::out_ctl_t  out_ctl,
    output clcd_pkg::dp_stat_t  stat,
    output clcd_pkg::out_item_t m_data
);
    import clcd_pkg::*;

    // Printed window: digits above it only decide whether leading zeros are shown.
    localparam int WIN = (MAX_DIGITS < DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;

    logic [2:0]           cmd_reg;
    logic [7:0]           data_reg;
    logic [NUM_W-1:0]     bin_reg;
    logic [3:0]           bcd_reg [DEC_DIGITS];
    logic [3:0]           bcd_next [DEC_DIGITS];
    logic [3:0]           adj [DEC_DIGITS];
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [DIG_IDX_W-1:0] idx_reg;

    logic [7:0]           col_clamp;
    logic [7:0]           addr;
    logic [7:0]           req_byte;
    logic [3:0]           digit;
    logic [7:0]           cur_byte;
    logic                 rs;
    logic                 upper_nz;
    logic [LONG_W:0]      long_sum;
    logic [WAIT_AFTER_W-1:0] settle_ext;
    logic [WAIT_AFTER_W-1:0] long_after;

    // Cursor address and the byte a request carries
    always_comb begin
        col_clamp = (s_data.column > 8'(LAST_COLUMN)) ? 8'(LAST_COLUMN) : s_data.column;
        addr      = s_data.line ? (col_clamp + LINE2_OFFSET) : col_clamp;
        case (s_data.command)
            CMD_CLEAR:  req_byte = BYTE_CLEAR;
            CMD_CURSOR: req_byte = SET_ADDR | addr;
            default:    req_byte = s_data.byte_value;
        endcase
    end

    // Shift-and-add-3 step, one input bit per cycle
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
        bcd_next[0] = {adj[0][2:0], bin_reg[NUM_W-1]};
        for (int i = 1; i < DEC_DIGITS; i++) begin
            bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cmd_reg  <= s_data.command;
            data_reg <= req_byte;
            bin_reg  <= s_data.number;
            for (int i = 0; i < DEC_DIGITS; i++) begin
                bcd_reg[i] <= '0;
            end
        end else if (cmd.conv_step) begin
            bin_reg <= {bin_reg[NUM_W-2:0], 1'b0};
            for (int i = 0; i < DEC_DIGITS; i++) begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
        end else begin
            if (cmd.latch) begin
                bit_cnt_reg <= '0;
            end else if (cmd.conv_step) begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end

            if (cmd.latch || cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_top) begin
                idx_reg <= DIG_IDX_W'(WIN - 1);
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end else if (cmd.idx_dec) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_comb begin
        upper_nz = 1'b0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (i >= WIN) begin
                upper_nz = upper_nz | (|bcd_reg[i]);
            end
        end
    end

    assign digit = bcd_reg[idx_reg];

    always_comb begin
        case (cmd_reg)
            CMD_INIT:   cur_byte = init_byte(idx_reg[1:0]);
            CMD_NUMBER: cur_byte = ASCII_ZERO | {4'b0, digit};
            default:    cur_byte = data_reg;
        endcase
    end

    assign rs = (cmd_reg == CMD_CHAR) || (cmd_reg == CMD_NUMBER);

    assign stat.cmd           = cmd_reg;
    assign stat.conv_done     = (bit_cnt_reg == BIT_CNT_W'(NUM_W - 1));
    assign stat.idx_zero      = (idx_reg == '0);
    assign stat.idx_init_last = (idx_reg == DIG_IDX_W'(INIT_LAST_IDX));
    assign stat.digit_zero    = (digit == 4'd0);
    assign stat.upper_nz      = upper_nz;

    // Clear and home get the long wait on top of the settle time, saturated
    always_comb begin
        long_sum   = (LONG_W+1)'(cfg.settle) + (LONG_W+1)'(cfg.long_wait);
        settle_ext = WAIT_AFTER_W'(cfg.settle);
        long_after = long_sum[LONG_W] ? WAIT_AFTER_MAX : long_sum[LONG_W-1:0];
    end

    always_comb begin
        m_data.rs             = rs;
        m_data.nibble         = cur_byte[7:4];
        m_data.wait_before_us = '0;
        m_data.wait_after_us  = settle_ext;
        m_data.last           = out_ctl.last;
        case (out_ctl.sel)
            OSEL_INIT: begin
                m_data.rs     = 1'b0;
                m_data.nibble = (idx_reg[1:0] == INIT_LAST_IDX) ? INIT_NIB_2 : INIT_NIB_3;
                case (idx_reg[1:0])
                    2'd0:    m_data.wait_before_us = cfg.power_on;
                    2'd1:    m_data.wait_before_us = INIT_WAIT_2;
                    2'd2:    m_data.wait_before_us = INIT_WAIT_3;
                    default: m_data.wait_before_us = '0;
                endcase
            end
            OSEL_LO: begin
                m_data.nibble = cur_byte[3:0];
                if (!rs && ((cur_byte == BYTE_CLEAR) || (cur_byte == BYTE_HOME))) begin
                    m_data.wait_after_us = long_after;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/clcd_ctrl.sv
// Controller state machine: sequences requests into nibble transfers.
module clcd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  clcd_pkg::dp_stat_t stat,
    output clcd_pkg::dp_cmd_t  cmd,
    output clcd_pkg::out_ctl_t out_ctl
);
    import clcd_pkg::*;
    `include "assert_macros.svh"

    state_t state_reg;
    state_t state_next;
    logic   final_xfer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        case (stat.cmd)
            CMD_INIT:   final_xfer = stat.idx_init_last;
            CMD_NUMBER: final_xfer = stat.idx_zero;
            default:    final_xfer = 1'b1;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd          = '0;
        out_ctl.sel  = OSEL_HI;
        out_ctl.last = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.cmd)
                    CMD_INIT:                        state_next = ST_INIT_NIB;
                    CMD_CLEAR, CMD_CURSOR, CMD_CHAR: state_next = ST_SEND_HI;
                    CMD_NUMBER:                      state_next = ST_CONVERT;
                    default:                         state_next = ST_IDLE;
                endcase
            end
            ST_INIT_NIB: begin
                m_valid     = 1'b1;
                out_ctl.sel = OSEL_INIT;
                if (m_ready) begin
                    if (stat.idx_init_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_SEND_HI;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_CONVERT: begin
                cmd.conv_step = 1'b1;
                if (stat.conv_done) begin
                    cmd.idx_top = 1'b1;
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros unless the number runs past the printed window
                if (!stat.upper_nz && !stat.idx_zero && stat.digit_zero) begin
                    cmd.idx_dec = 1'b1;
                end else begin
                    state_next = ST_SEND_HI;
                end
            end
            ST_SEND_HI: begin
                m_valid     = 1'b1;
                out_ctl.sel = OSEL_HI;
                if (m_ready) begin
                    state_next = ST_SEND_LO;
                end
            end
            ST_SEND_LO: begin
                m_valid      = 1'b1;
                out_ctl.sel  = OSEL_LO;
                out_ctl.last = final_xfer;
                if (m_ready) begin
                    if (final_xfer) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (stat.cmd == CMD_INIT) begin
                            cmd.idx_inc = 1'b1;
                        end else begin
                            cmd.idx_dec = 1'b1;
                        end
                        state_next = ST_SEND_HI;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `CLCD_ASSERT_IMP(a_no_overlap, aclk, aresetn, s_ready, !m_valid, "input taken while a transfer is pending")
    `CLCD_ASSERT_IMP(a_last_on_low, aclk, aresetn, m_valid && out_ctl.last, state_reg == ST_SEND_LO, "last flag outside a low nibble")
    `CLCD_ASSERT_NXT(a_last_frees, aclk, aresetn, m_valid && m_ready && out_ctl.last, s_ready, "block not idle after the final transfer")

endmodule

FILE: rtl/char_lcd_4bit_sequencer.sv
// Top level of the character LCD 4-bit sequencer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  s_       | s_valid / s_ready  | s_data  (in_item_t request)
//  m_       | m_valid / m_ready  | m_data  (out_item_t transfer)
//  cfg_     | cfg_wr_en          | cfg_index, cfg_wdata
//
// One request is in work at a time; s_ready is high only when idle.
// A request is accepted in idle and passes a dispatch state before its transfers.
// Write number first steps the shift-and-add-3 converter over every input bit,
// then drops leading zeros, then sends two transfers per digit.
// A stalled m_ready holds the current transfer and the sequencer in place.
// Synchronous active-low reset returns to idle and loads the register defaults.
module char_lcd_4bit_sequencer #(
    parameter int LAST_COLUMN = clcd_pkg::LAST_COLUMN_DEF,
    parameter int MAX_DIGITS  = clcd_pkg::MAX_DIGITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  clcd_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output clcd_pkg::out_item_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import clcd_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    out_ctl_t out_ctl;

    clcd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    clcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd),
        .out_ctl (out_ctl)
    );

    clcd_dp #(
        .LAST_COLUMN (LAST_COLUMN),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg),
        .cmd     (dp_cmd),
        .out_ctl (out_ctl),
        .stat    (dp_stat),
        .m_data  (m_data)
    );

endmodule
